// ===== rtl/core/tbc_pkg.sv =====
// Shared types and constants of the Trithemius byte cipher unit.
`default_nettype none

package tbc_pkg;

  // Polynomial terms in use; terms beyond the third have no register
  // and count as zero.
  localparam int unsigned NumCoeffs  = 3;
  localparam int unsigned KeywordMax = 8;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned KwIdxW   = 3;
  localparam int unsigned KwLenW   = 4;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 64;

  typedef enum logic [CfgIdxW-1:0] {
    CfgDecryptMode  = 3'd0,
    CfgKeyKind      = 3'd1,
    CfgCoefZero     = 3'd2,
    CfgCoefOne      = 3'd3,
    CfgCoefTwo      = 3'd4,
    CfgKeywordLen   = 3'd5,
    CfgKeywordShift = 3'd6
  } tbc_cfg_idx_e;

  typedef struct packed {
    logic              decrypt_mode;
    logic              key_kind;
    logic [ByteW-1:0]  coef_zero;
    logic [ByteW-1:0]  coef_one;
    logic [ByteW-1:0]  coef_two;
    logic [KwLenW-1:0] keyword_length;
    logic [63:0]       keyword_shift_pack;
  } tbc_cfg_t;

  // One classified byte as it travels from the front to the back.
  typedef struct packed {
    logic [ByteW-1:0]  data;
    logic              last;
    logic [ByteW-1:0]  pos;
    logic [ByteW-1:0]  pos_sq;
    logic [KwIdxW-1:0] kidx;
  } tbc_item_t;

endpackage

`default_nettype wire

// ===== rtl/core/tbc_if.sv =====
// Stream channels of the Trithemius byte cipher unit.
`default_nettype none

interface tbc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_of_message;
  logic       last_of_message;

  modport source (output valid, data_byte, first_of_message, last_of_message,
                  input ready);
  modport sink   (input valid, data_byte, first_of_message, last_of_message,
                  output ready);
endinterface

interface tbc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, out_byte, out_last, input ready);
  modport sink   (input valid, out_byte, out_last, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/tbc_front.sv =====
// Front end: tracks message position and keyword index, classifies each byte.
`default_nettype none

module tbc_front (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic [3:0]              keyword_length_i,
  input  wire logic                    in_valid_i,
  input  wire logic [7:0]              in_data_i,
  input  wire logic                    in_first_i,
  input  wire logic                    in_last_i,
  input  wire logic                    push_ok_i,
  output tbc_pkg::tbc_item_t           item_o,
  output logic                         push_o
);
  import tbc_pkg::*;

  logic [ByteW-1:0]  pos_q, pos_d;
  logic [KwIdxW-1:0] kidx_q, kidx_d;
  logic [ByteW-1:0]  pos;
  logic [KwIdxW-1:0] kidx_raw, kidx;
  logic [KwLenW-1:0] len_eff;
  logic [KwLenW-1:0] kidx_inc;
  logic [2*ByteW-1:0] sq_full;

  always_comb begin
    if (keyword_length_i == '0) begin
      len_eff = KwLenW'(1);
    end else if (keyword_length_i > KwLenW'(KeywordMax)) begin
      len_eff = KwLenW'(KeywordMax);
    end else begin
      len_eff = keyword_length_i;
    end
  end

  assign pos      = in_first_i ? '0 : pos_q;
  assign kidx_raw = in_first_i ? '0 : kidx_q;
  // Length lowered mid-message: fall back to entry 0.
  assign kidx     = ({1'b0, kidx_raw} >= len_eff) ? '0 : kidx_raw;
  assign kidx_inc = {1'b0, kidx} + KwLenW'(1);
  assign sq_full  = pos * pos;

  assign push_o = in_valid_i && push_ok_i;

  always_comb begin
    item_o.data   = in_data_i;
    item_o.last   = in_last_i;
    item_o.pos    = pos;
    item_o.pos_sq = sq_full[ByteW-1:0];
    item_o.kidx   = kidx;
  end

  always_comb begin
    pos_d  = pos_q;
    kidx_d = kidx_q;
    if (push_o) begin
      pos_d  = pos + ByteW'(1);
      kidx_d = (kidx_inc >= len_eff) ? '0 : kidx_inc[KwIdxW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      kidx_q <= '0;
    end else begin
      pos_q  <= pos_d;
      kidx_q <= kidx_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/tbc_fifo.sv =====
// Short queue of classified bytes between front and back.
`default_nettype none

module tbc_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire tbc_pkg::tbc_item_t item_i,
  input  wire logic               pop_i,
  output tbc_pkg::tbc_item_t      item_o,
  output logic                    full_o,
  output logic                    empty_o
);
  import tbc_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  tbc_item_t       mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/tbc_back.sv =====
// Back end: forms the shift, applies it and holds the result register.
`default_nettype none

module tbc_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire tbc_pkg::tbc_cfg_t  cfg_i,
  input  wire logic               avail_i,
  input  wire tbc_pkg::tbc_item_t item_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [7:0]              out_byte_o,
  output logic                    out_last_o
);
  import tbc_pkg::*;

  logic               valid_q, valid_d;
  logic [ByteW-1:0]   byte_q, byte_d;
  logic               last_q;
  logic [2*ByteW-1:0] lin_prod, quad_prod;
  logic [ByteW-1:0]   poly_shift, kw_shift, shift;

  assign lin_prod  = cfg_i.coef_one * item_i.pos;
  assign quad_prod = cfg_i.coef_two * item_i.pos_sq;

  always_comb begin
    poly_shift = cfg_i.coef_zero;
    if (NumCoeffs > 1) begin
      poly_shift = poly_shift + lin_prod[ByteW-1:0];
    end
    if (NumCoeffs > 2) begin
      poly_shift = poly_shift + quad_prod[ByteW-1:0];
    end
  end

  assign kw_shift = cfg_i.keyword_shift_pack[item_i.kidx*ByteW +: ByteW];
  assign shift    = cfg_i.key_kind ? kw_shift : poly_shift;
  assign byte_d   = cfg_i.decrypt_mode ? (item_i.data - shift) : (item_i.data + shift);

  // Take the next item when the result register is free or being drained.
  assign pop_o   = avail_i && (!valid_q || out_ready_i);
  assign valid_d = pop_o || (valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      byte_q <= byte_d;
      last_q <= item_i.last;
    end
  end

  assign out_valid_o = valid_q;
  assign out_byte_o  = byte_q;
  assign out_last_o  = last_q;

endmodule

`default_nettype wire

// ===== rtl/core/trithemius_byte_cipher_unit.sv =====
// Top level of the Trithemius byte cipher unit.
`default_nettype none

// Encrypts or decrypts a byte stream with a position-dependent shift modulo
// 256, either a quadratic polynomial of the position or a cyclic keyword of
// up to eight shift values. One byte is taken per cycle while the queue is
// not full. The front squares the position into the queue, the back does
// the multiply-add and the add or subtract into the result register, which
// drives the output. FIFO_DEPTH sets the queue between the two; with the
// output stalled the input keeps taking bytes until it fills.
// Write configuration only while no byte is in flight.
module trithemius_byte_cipher_unit #(
  parameter int unsigned FIFO_DEPTH = 2
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [63:0] cfg_wdata_i,
  tbc_in_if.sink           in_i,
  tbc_out_if.source        out_o
);
  import tbc_pkg::*;

  tbc_cfg_t  cfg_q;
  tbc_item_t push_item, pop_item;
  logic      push, pop, fifo_full, fifo_empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{decrypt_mode: 1'b0, key_kind: 1'b0, coef_zero: '0, coef_one: '0,
                 coef_two: '0, keyword_length: KwLenW'(1), keyword_shift_pack: '0};
    end else if (cfg_we_i) begin
      unique case (tbc_cfg_idx_e'(cfg_idx_i))
        CfgDecryptMode:  cfg_q.decrypt_mode       <= cfg_wdata_i[0];
        CfgKeyKind:      cfg_q.key_kind           <= cfg_wdata_i[0];
        CfgCoefZero:     cfg_q.coef_zero          <= cfg_wdata_i[ByteW-1:0];
        CfgCoefOne:      cfg_q.coef_one           <= cfg_wdata_i[ByteW-1:0];
        CfgCoefTwo:      cfg_q.coef_two           <= cfg_wdata_i[ByteW-1:0];
        CfgKeywordLen:   cfg_q.keyword_length     <= cfg_wdata_i[KwLenW-1:0];
        CfgKeywordShift: cfg_q.keyword_shift_pack <= cfg_wdata_i;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  assign in_i.ready = !fifo_full;

  tbc_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .keyword_length_i (cfg_q.keyword_length),
    .in_valid_i       (in_i.valid),
    .in_data_i        (in_i.data_byte),
    .in_first_i       (in_i.first_of_message),
    .in_last_i        (in_i.last_of_message),
    .push_ok_i        (!fifo_full),
    .item_o           (push_item),
    .push_o           (push)
  );

  tbc_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .pop_i   (pop),
    .item_o  (pop_item),
    .full_o  (fifo_full),
    .empty_o (fifo_empty)
  );

  tbc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .avail_i     (!fifo_empty),
    .item_i      (pop_item),
    .pop_o       (pop),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_byte_o  (out_o.out_byte),
    .out_last_o  (out_o.out_last)
  );

  a_fifo_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(fifo_full && fifo_empty))
    else $error("queue reports full and empty at once");

  a_push_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !pop |=> !fifo_empty)
    else $error("pushed byte missing from queue");

  a_first_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && in_i.first_of_message |-> push_item.pos == '0 && push_item.kidx == '0)
    else $error("message start did not restart position");

  a_pop_fills_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> out_o.valid)
    else $error("popped byte not presented");

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of the Trithemius byte cipher unit.
module testbench;
  import tbc_pkg::*;

  localparam logic [CfgIdxW-1:0] CfgUnusedIdx = 3'd7;
  localparam int unsigned MsgCap = 40;

  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic             out_last;
  } cipher_byte_t;

  class cipher_scoreboard;
    tbc_cfg_t          cfg;
    logic [ByteW-1:0]  position;
    logic [KwIdxW-1:0] kw_index;
    cipher_byte_t      cipher_q[$];
    int                errors;

    function new();
      cfg = '0;
      cfg.keyword_length = KwLenW'(1);
      position = '0;
      kw_index = '0;
      errors = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] value);
      case (idx)
        CfgDecryptMode:  cfg.decrypt_mode = value[0];
        CfgKeyKind:      cfg.key_kind = value[0];
        CfgCoefZero:     cfg.coef_zero = value[ByteW-1:0];
        CfgCoefOne:      cfg.coef_one = value[ByteW-1:0];
        CfgCoefTwo:      cfg.coef_two = value[ByteW-1:0];
        CfgKeywordLen:   cfg.keyword_length = value[KwLenW-1:0];
        CfgKeywordShift: cfg.keyword_shift_pack = value;
        default: ;
      endcase
    endfunction

    // Sum of coefficient times position power, all in 8-bit arithmetic.
    function logic [ByteW-1:0] poly_shift(logic [ByteW-1:0] pos);
      logic [ByteW-1:0] sum;
      logic [ByteW-1:0] power;
      logic [ByteW-1:0] coef;
      sum = '0;
      power = 8'd1;
      for (int j = 0; j < NumCoeffs; j++) begin
        case (j)
          0:       coef = cfg.coef_zero;
          1:       coef = cfg.coef_one;
          2:       coef = cfg.coef_two;
          default: coef = '0;
        endcase
        sum = sum + coef * power;
        power = power * pos;
      end
      return sum;
    endfunction

    function void note_input(logic [ByteW-1:0] data, logic first, logic last);
      logic [ByteW-1:0]  pos;
      logic [KwIdxW-1:0] kidx;
      logic [ByteW-1:0]  shift;
      int unsigned       len;
      cipher_byte_t      res;
      pos = first ? '0 : position;
      kidx = first ? '0 : kw_index;
      len = cfg.keyword_length;
      if (len == 0) len = 1;
      if (len > KeywordMax) len = KeywordMax;
      // A length lowered mid-message falls back to entry 0.
      if (kidx >= len) kidx = '0;
      if (cfg.key_kind)
        shift = cfg.keyword_shift_pack[kidx*8 +: 8];
      else
        shift = poly_shift(pos);
      res.out_byte = cfg.decrypt_mode ? data - shift : data + shift;
      res.out_last = last;
      cipher_q = {cipher_q, res};
      position = pos + 8'd1;
      kw_index = (kidx + 1 >= len) ? '0 : KwIdxW'(kidx + 1);
    endfunction

    function int pending();
      return cipher_q.size();
    endfunction

    task report(string what);
      $display("%0t ns: %s", $time, what);
      errors++;
    endtask

    task check_output(logic [ByteW-1:0] got_byte, logic got_last);
      cipher_byte_t want;
      if (cipher_q.size() == 0) begin
        report($sformatf("output byte %02h with nothing pending", got_byte));
        return;
      end
      want = cipher_q.pop_front();
      if (got_byte !== want.out_byte)
        report($sformatf("out_byte %02h, want %02h", got_byte, want.out_byte));
      if (got_last !== want.out_last)
        report($sformatf("out_last %b, want %b", got_last, want.out_last));
    endtask
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  cipher_scoreboard sb = new();

  tbc_in_if  in_bus ();
  tbc_out_if out_bus ();

  trithemius_byte_cipher_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_bus),
    .out_o       (out_bus)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  initial begin
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      out_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_bus.valid && out_bus.ready)
      sb.check_output(out_bus.out_byte, out_bus.out_last);
  end

  task automatic push_byte(logic [ByteW-1:0] data, logic first, logic last);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_bus.valid <= 1'b1;
    in_bus.data_byte <= data;
    in_bus.first_of_message <= first;
    in_bus.last_of_message <= last;
    do @(posedge clk_i); while (!in_bus.ready);
    sb.note_input(data, first, last);
  endtask

  // Hold the input until every pending byte has come out.
  task automatic settle();
    @(negedge clk_i);
    in_bus.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    sb.write_reg(idx, value);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [ByteW-1:0] pick_byte();
    case ($urandom_range(3))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return ByteW'($urandom_range(255));
    endcase
  endfunction

  task automatic rekey();
    logic [CfgDataW-1:0] pack;
    case ($urandom_range(5))
      0:       pack = '0;
      1:       pack = '1;
      default: pack = {$urandom, $urandom};
    endcase
    write_reg(CfgDecryptMode, CfgDataW'($urandom_range(1)));
    write_reg(CfgKeyKind, CfgDataW'($urandom_range(1)));
    write_reg(CfgCoefZero, CfgDataW'(pick_byte()));
    write_reg(CfgCoefOne, CfgDataW'(pick_byte()));
    write_reg(CfgCoefTwo, CfgDataW'(pick_byte()));
    // Mostly legal lengths; now and then zero or above the maximum.
    write_reg(CfgKeywordLen, CfgDataW'(($urandom_range(3) == 0) ?
                                       $urandom_range(15) : $urandom_range(8, 1)));
    write_reg(CfgKeywordShift, pack);
    if ($urandom_range(4) == 0) write_reg(CfgUnusedIdx, {$urandom, $urandom});
  endtask

  task automatic send_stream(int count, bit one_message);
    int remaining;
    int msg_len;
    bit broken;
    remaining = count;
    while (remaining > 0) begin
      if (one_message)
        msg_len = remaining;
      else if ($urandom_range(11) == 0)
        msg_len = $urandom_range(120, 60);
      else
        msg_len = $urandom_range(MsgCap, 1);
      if (msg_len > remaining) msg_len = remaining;
      // Start some messages without a first mark so position carries over.
      broken = ($urandom_range(7) == 0);
      if ($urandom_range(19) == 0) settle();
      for (int i = 0; i < msg_len; i++) begin
        if ($urandom_range(15) == 0)
          push_byte(pick_byte(), 1'($urandom_range(1)), 1'($urandom_range(1)));
        else
          push_byte(pick_byte(), (i == 0) && !broken, i == msg_len - 1);
      end
      remaining -= msg_len;
    end
  endtask

  initial begin
    bit wrap_seg;
    in_bus.valid = 1'b0;
    in_bus.data_byte = '0;
    in_bus.first_of_message = 1'b0;
    in_bus.last_of_message = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_wdata_i = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset key is an all-zero polynomial: bytes pass unchanged.
    push_byte(8'h00, 1'b1, 1'b0);
    push_byte(8'hFF, 1'b0, 1'b1);
    settle();
    write_reg(CfgCoefZero, 64'hFF);
    write_reg(CfgCoefOne, 64'hFF);
    write_reg(CfgCoefTwo, 64'hFF);
    push_byte(8'hFF, 1'b1, 1'b0);
    push_byte(8'h00, 1'b0, 1'b0);
    push_byte(8'hA5, 1'b0, 1'b0);
    push_byte(8'h5A, 1'b0, 1'b1);
    settle();
    write_reg(CfgDecryptMode, 64'd1);
    push_byte(8'hFF, 1'b1, 1'b0);
    push_byte(8'h00, 1'b0, 1'b0);
    push_byte(8'h80, 1'b0, 1'b1);
    settle();
    write_reg(CfgKeyKind, 64'd1);
    write_reg(CfgKeywordLen, 64'd8);
    write_reg(CfgKeywordShift, 64'h80FF_0102_7F40_2010);
    write_reg(CfgDecryptMode, 64'd0);
    push_byte(8'h00, 1'b1, 1'b0);
    for (int i = 0; i < 5; i++) push_byte(8'hFF, 1'b0, 1'b0);
    settle();
    // Shorten the keyword mid-message: the index now lies past the length.
    write_reg(CfgKeywordLen, 64'd3);
    for (int i = 0; i < 3; i++) push_byte(8'h7E, 1'b0, 1'b0);
    settle();
    write_reg(CfgKeywordLen, 64'd0);
    push_byte(8'h01, 1'b0, 1'b0);
    push_byte(8'hFE, 1'b0, 1'b1);
    settle();
    write_reg(CfgKeywordLen, 64'd15);
    push_byte(8'h33, 1'b1, 1'b0);
    push_byte(8'hCC, 1'b0, 1'b0);
    settle();
    write_reg(CfgUnusedIdx, '1);
    push_byte(8'h55, 1'b0, 1'b1);

    for (int phase = 0; phase < 3; phase++) begin
      for (int seg = 0; seg < 6; seg++) begin
        settle();
        case (phase)
          0: begin
            send_idle_pct = 35;
            recv_idle_pct = 84;
          end
          1: begin
            send_idle_pct = 84;
            recv_idle_pct = 35;
          end
          default: begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
          end
        endcase
        rekey();
        // One long polynomial message of 270 bytes; stray first marks may restart its position.
        wrap_seg = (phase == 2) && (seg == 5);
        if (wrap_seg) write_reg(CfgKeyKind, 64'd0);
        send_stream(wrap_seg ? 270 : 52, wrap_seg);
      end
    end

    settle();
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/tbc_pkg.sv
rtl/core/tbc_if.sv
rtl/core/tbc_front.sv
rtl/core/tbc_fifo.sv
rtl/core/tbc_back.sv
rtl/core/trithemius_byte_cipher_unit.sv
dv/testbench.sv
